// File: sv/fcrd_pkg.sv
`default_nettype none

package fcrd_pkg;

    localparam int CNT_W            = 7;
    localparam int SYM_W            = 32;
    localparam int DEF_MAX_RULE_LEN = 64;
    localparam int DEF_SYMBOL_BITS  = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic OP_BEGIN  = 1'b0;
    localparam logic OP_SUFFIX = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_CLAMP = 2'd1,
        ERR_DROP  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CMD_PREFIX   = 2'd0,
        CMD_SUFFIX   = 2'd1,
        CMD_OVERFLOW = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CNT_W-1:0]  cnt;
        logic [SYM_W-1:0]  sym;
        logic              start;
        err_t              err;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic last;
        err_t err;
    } res_flags_t;

endpackage

`default_nettype wire

// File: sv/fcrd_if.sv
`default_nettype none

interface fcrd_in_if import fcrd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [CNT_W-1:0] prefix_len;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output op, output prefix_len, output symbol, input ready);
    modport sink   (input valid, input op, input prefix_len, input symbol, output ready);
endinterface

interface fcrd_out_if import fcrd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_symbol;
    logic             rule_head;
    logic             last;
    logic [1:0]       error;

    modport source (output valid, output out_symbol, output rule_head, output last,
                    output error, input ready);
    modport sink   (input valid, input out_symbol, input rule_head, input last,
                    input error, output ready);
endinterface

`default_nettype wire

// File: sv/front_coded_rule_decoder_core.sv
// Path: a suffix item passes through the command queue and the output register; the
// re-emitted prefix symbols of a begin item pass through the queue, the buffer read
// register and the output register. A begin item that keeps k symbols issues one read
// of the single-port rule buffer per symbol; output back-pressure stalls the reads.
// Reset clears the rule length, arms the rule-start flag, empties the command queue
// and clears all valid flags; the rule buffer keeps its contents and needs no clearing.
`default_nettype none

module front_coded_rule_decoder_core import fcrd_pkg::*; #(
    parameter int MAX_RULE_LEN = DEF_MAX_RULE_LEN,
    parameter int SYMBOL_BITS  = DEF_SYMBOL_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    fcrd_in_if.sink    item_ch,
    fcrd_out_if.source result_ch
);

    logic push;
    logic push_ready;
    cmd_t push_cmd;
    logic head_valid;
    logic pop;
    cmd_t head_cmd;

    fcrd_front #(
        .MAX_RULE_LEN (MAX_RULE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    fcrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .head_cmd   (head_cmd)
    );

    fcrd_back #(
        .MAX_RULE_LEN (MAX_RULE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .result_ch  (result_ch)
    );

endmodule

`default_nettype wire

// File: sv/fcrd_front.sv
`default_nettype none

module fcrd_front import fcrd_pkg::*; #(
    parameter int MAX_RULE_LEN = DEF_MAX_RULE_LEN,
    parameter int SYMBOL_BITS  = DEF_SYMBOL_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    fcrd_in_if.sink   item_ch,
    output logic      push,
    input  logic      push_ready,
    output cmd_t      push_cmd
);

    localparam int LEN_W   = $clog2(MAX_RULE_LEN + 1);
    localparam int STORE_W = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             pend_reg;
    logic             pend_next;

    logic             accept;
    logic             clamp;
    logic [CNT_W-1:0] len_ext;
    logic [CNT_W-1:0] keep;

    assign item_ch.ready = push_ready;
    assign accept        = item_ch.valid && push_ready;
    assign len_ext       = CNT_W'(len_reg);
    assign clamp         = item_ch.prefix_len > len_ext;
    assign keep          = clamp ? len_ext : item_ch.prefix_len;

    always_comb
    begin
        len_next       = len_reg;
        pend_next      = pend_reg;
        push           = 1'b0;
        push_cmd       = '0;
        push_cmd.kind  = CMD_PREFIX;
        push_cmd.err   = ERR_NONE;
        if (item_ch.op == OP_BEGIN)
        begin
            push_cmd.kind  = CMD_PREFIX;
            push_cmd.cnt   = keep;
            push_cmd.start = 1'b1;
            push_cmd.err   = clamp ? ERR_CLAMP : ERR_NONE;
            push           = item_ch.valid && (keep != '0);
            if (accept)
            begin
                len_next  = LEN_W'(keep);
                pend_next = (keep == '0);
            end
        end
        else if (len_reg == LEN_W'(MAX_RULE_LEN))
        begin
            push_cmd.kind = CMD_OVERFLOW;
            push_cmd.err  = ERR_DROP;
            push          = item_ch.valid;
        end
        else
        begin
            push_cmd.kind  = CMD_SUFFIX;
            push_cmd.cnt   = len_ext;
            push_cmd.sym   = SYM_W'(item_ch.symbol[STORE_W-1:0]);
            push_cmd.start = pend_reg;
            push           = item_ch.valid;
            if (accept)
            begin
                len_next  = len_reg + LEN_W'(1);
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            pend_reg <= 1'b1;
        end
        else
        begin
            len_reg  <= len_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/fcrd_queue.sv
`default_nettype none

module fcrd_queue import fcrd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic head_valid,
    input  logic pop,
    output cmd_t head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg;
    logic [CNT_QW-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = fill_reg != CNT_QW'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_cmd   = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/fcrd_back.sv
`default_nettype none

module fcrd_back import fcrd_pkg::*; #(
    parameter int MAX_RULE_LEN = DEF_MAX_RULE_LEN,
    parameter int SYMBOL_BITS  = DEF_SYMBOL_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    fcrd_out_if.source result_ch
);

    localparam int IDX_W   = $clog2(MAX_RULE_LEN);
    localparam int STORE_W = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

    logic [STORE_W-1:0] buf_mem [MAX_RULE_LEN];
    logic [STORE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               dv_reg;
    logic               dv_next;
    res_flags_t         dv_flags_reg;
    res_flags_t         dv_flags_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SYM_W-1:0]   out_sym_reg;
    logic [SYM_W-1:0]   out_sym_next;
    res_flags_t         out_flags_reg;
    res_flags_t         out_flags_next;

    logic               out_free;
    logic               can_issue;
    logic               is_prefix;
    logic               idx_last;
    logic               rd_en;
    logic               emit;
    logic               wr_en;

    assign out_free  = !out_valid_reg || result_ch.ready;
    assign can_issue = !dv_reg || out_free;
    assign is_prefix = head_cmd.kind == CMD_PREFIX;
    assign idx_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == head_cmd.cnt;
    assign rd_en     = head_valid && is_prefix && can_issue;
    assign emit      = head_valid && !is_prefix && !dv_reg && out_free;
    assign wr_en     = emit && (head_cmd.kind == CMD_SUFFIX);
    assign pop       = (rd_en && idx_last) || emit;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.out_symbol = out_sym_reg;
    assign result_ch.rule_head  = out_flags_reg.start;
    assign result_ch.last       = out_flags_reg.last;
    assign result_ch.error      = out_flags_reg.err;

    always_comb
    begin
        idx_next       = idx_reg;
        dv_flags_next  = dv_flags_reg;
        dv_next        = dv_reg && !out_free;
        out_valid_next = out_valid_reg;
        out_sym_next   = out_sym_reg;
        out_flags_next = out_flags_reg;

        if (rd_en)
        begin
            idx_next            = idx_last ? '0 : idx_reg + IDX_W'(1);
            dv_next             = 1'b1;
            dv_flags_next.start = (idx_reg == '0);
            dv_flags_next.last  = idx_last;
            dv_flags_next.err   = head_cmd.err;
        end

        if (dv_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = SYM_W'(rd_data_reg);
            out_flags_next = dv_flags_reg;
        end
        else if (emit)
        begin
            out_valid_next       = 1'b1;
            out_sym_next         = head_cmd.sym;
            out_flags_next.start = head_cmd.start;
            out_flags_next.last  = 1'b1;
            out_flags_next.err   = head_cmd.err;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[head_cmd.cnt[IDX_W-1:0]] <= head_cmd.sym[STORE_W-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= buf_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_flags_reg  <= dv_flags_next;
        out_sym_reg   <= out_sym_next;
        out_flags_reg <= out_flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
